/* rtl/ezp_pkg.sv */
// ----------------------------------------------------------------------------
// ezp_pkg
// Types, constants and coefficient tables for the Euler ZYX pose converter.
// ----------------------------------------------------------------------------
package ezp_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int RB             = ANGLE_BITS - 2;
  localparam int WQ             = 30;
  localparam int SQ             = 20;
  localparam int X_W            = 31;
  localparam int X2_W           = 32;
  localparam int T_W            = WQ + 1;
  localparam int SC_W           = 22;
  localparam int KW             = 8;
  localparam int RCP_W          = 32;
  localparam int SIN_STEPS      = 5;
  localparam int COS_STEPS      = 6;
  localparam int CELL_LAT       = 3;
  localparam int SC_LAT         = 2 + CELL_LAT * COS_STEPS + 1;
  localparam int MX_LAT         = 4;
  localparam int LAT            = SC_LAT + MX_LAT;
  localparam int OUT_SHIFT      = 60 - COEF_FRAC_BITS;

  localparam logic [X_W-1:0] HALF_PI_WQ = 31'd1686629713;
  localparam logic [T_W-1:0] ONE_WQ     = T_W'(1) << WQ;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } out_item_t;

  typedef struct packed {
    logic signed [SC_W-1:0] sn;
    logic signed [SC_W-1:0] cs;
  } sc_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  // nested Taylor divisors and floor(2^32 / k)
  function automatic logic [KW-1:0] sin_k(input logic [2:0] i);
    logic [KW-1:0] k;
    case (i)
      3'd0:    k = 8'd110;
      3'd1:    k = 8'd72;
      3'd2:    k = 8'd42;
      3'd3:    k = 8'd20;
      default: k = 8'd6;
    endcase
    return k;
  endfunction

  function automatic logic [RCP_W-1:0] sin_rcp(input logic [2:0] i);
    logic [RCP_W-1:0] m;
    case (i)
      3'd0:    m = 32'd39045157;
      3'd1:    m = 32'd59652323;
      3'd2:    m = 32'd102261126;
      3'd3:    m = 32'd214748364;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

  function automatic logic [KW-1:0] cos_k(input logic [2:0] i);
    logic [KW-1:0] k;
    case (i)
      3'd0:    k = 8'd132;
      3'd1:    k = 8'd90;
      3'd2:    k = 8'd56;
      3'd3:    k = 8'd30;
      3'd4:    k = 8'd12;
      default: k = 8'd2;
    endcase
    return k;
  endfunction

  function automatic logic [RCP_W-1:0] cos_rcp(input logic [2:0] i);
    logic [RCP_W-1:0] m;
    case (i)
      3'd0:    m = 32'd32537631;
      3'd1:    m = 32'd47721858;
      3'd2:    m = 32'd76695844;
      3'd3:    m = 32'd143165576;
      3'd4:    m = 32'd357913941;
      default: m = 32'd2147483648;
    endcase
    return m;
  endfunction

endpackage

/* rtl/ezp_nest_cell.sv */
// ----------------------------------------------------------------------------
// ezp_nest_cell
// One nested Taylor step: t = ONE - min(ONE, floor(x2*t / 2^30) / k).
// Three stages; x2 travels alongside to the next cell.
// ----------------------------------------------------------------------------
module ezp_nest_cell import ezp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [X2_W-1:0]  x2_in,
  input  logic [T_W-1:0]   t_in,
  input  logic [KW-1:0]    k,
  input  logic [RCP_W-1:0] rcp,
  output logic [X2_W-1:0]  x2_out,
  output logic [T_W-1:0]   t_out
);

  logic [X2_W-1:0]        x2_r [CELL_LAT];
  logic [X2_W+T_W-1:0]    prod;
  logic [31:0]            n_a_r, n_b_r, q0_r;
  logic [X2_W+RCP_W-1:0]  qm;
  logic [39:0]            qk, rem;
  logic [31:0]            p;
  logic [T_W-1:0]         t_r;

  assign prod = x2_in * t_in;
  assign qm   = n_a_r * rcp;
  assign qk   = {8'd0, q0_r} * {32'd0, k};
  assign rem  = {8'd0, n_b_r} - qk;

  always_comb begin
    if (rem >= {31'd0, k, 1'b0})
      p = q0_r + 32'd2;
    else if (rem >= {32'd0, k})
      p = q0_r + 32'd1;
    else
      p = q0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_a_r    <= prod[WQ +: 32];
      q0_r     <= qm[X2_W+RCP_W-1 -: 32];
      n_b_r    <= n_a_r;
      t_r      <= (p > {1'b0, ONE_WQ}) ? '0 : ONE_WQ - p[T_W-1:0];
      x2_r[0]  <= x2_in;
      for (int i = 1; i < CELL_LAT; i++)
        x2_r[i] <= x2_r[i-1];
    end
  end

  assign x2_out = x2_r[CELL_LAT-1];
  assign t_out  = t_r;

endmodule

/* rtl/ezp_sincos.sv */
// ----------------------------------------------------------------------------
// ezp_sincos
// Sine and cosine of a binary angle in Q20, via two chains of nested
// Taylor cells and a quadrant fold.
// ----------------------------------------------------------------------------
module ezp_sincos import ezp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] angle,
  output sc_t         sc
);

  logic [ANGLE_BITS-1:0] u;
  logic [RB-1:0]         r;
  logic [1:0]            q;
  logic [RB+X_W-1:0]     xm;
  logic [X_W-1:0]        x_r;
  logic [2*X_W-1:0]      xx;
  logic [X2_W-1:0]       x2_r;
  logic [1:0]            q_r;
  logic [X_W-1:0]        xd_r [16];
  logic [1:0]            qd_r [19];
  logic [X_W+T_W-1:0]    sm;
  logic [T_W-1:0]        s0_r;
  logic [T_W-1:0]        s0d_r [2];
  logic [X2_W-1:0]       x2_s [SIN_STEPS+1];
  logic [T_W-1:0]        t_s  [SIN_STEPS+1];
  logic [X2_W-1:0]       x2_c [COS_STEPS+1];
  logic [T_W-1:0]        t_c  [COS_STEPS+1];
  logic signed [31:0]    sv, cv;
  sc_t                   sc_r;

  // binary angle wraps at ANGLE_BITS
  assign u  = ANGLE_BITS'(signed'(angle));
  assign q  = u[ANGLE_BITS-1 -: 2];
  assign r  = u[RB-1:0];
  assign xm = r * HALF_PI_WQ;
  assign xx = x_r * x_r;

  assign x2_s[0] = x2_r;
  assign t_s[0]  = ONE_WQ;
  assign x2_c[0] = x2_r;
  assign t_c[0]  = ONE_WQ;

  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    ezp_nest_cell u_cell (
      .clk(clk), .en(en), .x2_in(x2_s[i]), .t_in(t_s[i]),
      .k(sin_k(3'(i))), .rcp(sin_rcp(3'(i))),
      .x2_out(x2_s[i+1]), .t_out(t_s[i+1])
    );
  end

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    ezp_nest_cell u_cell (
      .clk(clk), .en(en), .x2_in(x2_c[i]), .t_in(t_c[i]),
      .k(cos_k(3'(i))), .rcp(cos_rcp(3'(i))),
      .x2_out(x2_c[i+1]), .t_out(t_c[i+1])
    );
  end

  assign sm = xd_r[15] * t_s[SIN_STEPS];

  always_comb begin
    case (qd_r[18])
      2'd0: begin
        sv = 32'(s0d_r[1]);    cv = 32'(t_c[COS_STEPS]);
      end
      2'd1: begin
        sv = 32'(t_c[COS_STEPS]);   cv = -32'(s0d_r[1]);
      end
      2'd2: begin
        sv = -32'(s0d_r[1]);   cv = -32'(t_c[COS_STEPS]);
      end
      default: begin
        sv = -32'(t_c[COS_STEPS]);  cv = 32'(s0d_r[1]);
      end
    endcase
  end

  function automatic logic signed [SC_W-1:0] rnd(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [31:0] m;
    mag = v[31] ? 32'(-v) : 32'(v);
    m   = (mag + (32'd1 << (WQ - SQ - 1))) >> (WQ - SQ);
    return v[31] ? -SC_W'(m) : SC_W'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      x_r      <= xm[RB +: X_W];
      q_r      <= q;
      x2_r     <= xx[WQ +: X2_W];
      xd_r[0]  <= x_r;
      for (int i = 1; i < 16; i++)
        xd_r[i] <= xd_r[i-1];
      qd_r[0]  <= q_r;
      for (int i = 1; i < 19; i++)
        qd_r[i] <= qd_r[i-1];
      s0_r     <= sm[WQ +: T_W];
      s0d_r[0] <= s0_r;
      s0d_r[1] <= s0d_r[0];
      sc_r.sn  <= rnd(sv);
      sc_r.cs  <= rnd(cv);
    end
  end

  assign sc = sc_r;

endmodule

/* rtl/ezp_matrix.sv */
// ----------------------------------------------------------------------------
// ezp_matrix
// Forms Rz*Ry*Rx from Q20 sines and cosines exactly in Q60 and rounds each
// entry to the output precision.
// ----------------------------------------------------------------------------
module ezp_matrix import ezp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  sc_t         yaw,
  input  sc_t         pitch,
  input  sc_t         roll,
  output logic [15:0] ent [9]
);

  logic signed [43:0] czcy_r, czsy_r, szcx_r, szsx_r, szcy_r;
  logic signed [43:0] szsy_r, czcx_r, czsx_r, cysx_r, cycx_r;
  logic signed [SC_W-1:0] sx_r, cx_r, sy_r;
  logic signed [63:0] t01_r, t02_r, t11_r, t12_r;
  logic signed [63:0] e00_r, e01_r, e02_r, e10_r, e11_r, e12_r, e20_r, e21_r, e22_r;
  logic signed [63:0] v_r [9];
  logic [15:0]        ent_r [9];

  function automatic logic [15:0] rnd(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m   = (mag + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    return v[63] ? 16'(-m) : 16'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      czcy_r <= 44'(yaw.cs * pitch.cs);
      czsy_r <= 44'(yaw.cs * pitch.sn);
      szcx_r <= 44'(yaw.sn * roll.cs);
      szsx_r <= 44'(yaw.sn * roll.sn);
      szcy_r <= 44'(yaw.sn * pitch.cs);
      szsy_r <= 44'(yaw.sn * pitch.sn);
      czcx_r <= 44'(yaw.cs * roll.cs);
      czsx_r <= 44'(yaw.cs * roll.sn);
      cysx_r <= 44'(pitch.cs * roll.sn);
      cycx_r <= 44'(pitch.cs * roll.cs);
      sx_r   <= roll.sn;
      cx_r   <= roll.cs;
      sy_r   <= pitch.sn;

      t01_r  <= 64'(czsy_r * sx_r);
      t02_r  <= 64'(czsy_r * cx_r);
      t11_r  <= 64'(szsy_r * sx_r);
      t12_r  <= 64'(szsy_r * cx_r);
      e00_r  <= 64'(czcy_r) <<< 20;
      e01_r  <= 64'(szcx_r) <<< 20;
      e02_r  <= 64'(szsx_r) <<< 20;
      e10_r  <= 64'(szcy_r) <<< 20;
      e11_r  <= 64'(czcx_r) <<< 20;
      e12_r  <= 64'(czsx_r) <<< 20;
      e20_r  <= -(64'(sy_r) <<< 40);
      e21_r  <= 64'(cysx_r) <<< 20;
      e22_r  <= 64'(cycx_r) <<< 20;

      v_r[0] <= e00_r;
      v_r[1] <= t01_r - e01_r;
      v_r[2] <= t02_r + e02_r;
      v_r[3] <= e10_r;
      v_r[4] <= t11_r + e11_r;
      v_r[5] <= t12_r - e12_r;
      v_r[6] <= e20_r;
      v_r[7] <= e21_r;
      v_r[8] <= e22_r;

      for (int i = 0; i < 9; i++)
        ent_r[i] <= rnd(v_r[i]);
    end
  end

  assign ent = ent_r;

endmodule

/* rtl/euler_zyx_to_pose_matrix.sv */
// ----------------------------------------------------------------------------
// euler_zyx_to_pose_matrix
// Converts yaw, pitch and roll binary angles plus a position into the
// rotation entries and translation column of a pose matrix.
// ----------------------------------------------------------------------------
// One item in, one item out. Takes an item every cycle while not halted.
// Depth is set by the chain of six nested Taylor cells (three stages each)
// that forms the cosine, plus the fold, product, sum and rounding stages.
// The whole pipeline halts only while the output register holds an item and
// out_stall is high.
module euler_zyx_to_pose_matrix import ezp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        en;
  logic [LAT-1:0] vld_r;
  pos_t        pos_r [LAT];
  sc_t         yaw_sc, pitch_sc, roll_sc;
  logic [15:0] ent [9];

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;

  ezp_sincos u_yaw   (.clk(clk), .en(en), .angle(in_data.yaw_angle),   .sc(yaw_sc));
  ezp_sincos u_pitch (.clk(clk), .en(en), .angle(in_data.pitch_angle), .sc(pitch_sc));
  ezp_sincos u_roll  (.clk(clk), .en(en), .angle(in_data.roll_angle),  .sc(roll_sc));

  ezp_matrix u_matrix (
    .clk(clk), .en(en), .yaw(yaw_sc), .pitch(pitch_sc), .roll(roll_sc), .ent(ent)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r[0] <= '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
      for (int i = 1; i < LAT; i++)
        pos_r[i] <= pos_r[i-1];
    end
  end

  assign out_valid        = vld_r[LAT-1];
  assign out_data.r00     = ent[0];
  assign out_data.r01     = ent[1];
  assign out_data.r02     = ent[2];
  assign out_data.r10     = ent[3];
  assign out_data.r11     = ent[4];
  assign out_data.r12     = ent[5];
  assign out_data.r20     = ent[6];
  assign out_data.r21     = ent[7];
  assign out_data.r22     = ent[8];
  assign out_data.trans_x = pos_r[LAT-1].x;
  assign out_data.trans_y = pos_r[LAT-1].y;
  assign out_data.trans_z = pos_r[LAT-1].z;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Pose converter testbench
// Drives pose items into euler_zyx_to_pose_matrix through directed corner
// angles and positions, then random poses under several idling patterns,
// and checks every result against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench import ezp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD    = 20;
  localparam int N_RANDOM  = 1530;
  localparam int CYC_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  euler_zyx_to_pose_matrix DUT (.*);

  always #(PERIOD/2) clk = ~clk;

  out_item_t pose_q[$];
  int        n_errors = 0;
  int        n_checked = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_off = 1'b0;

  typedef struct {
    in_item_t  pose;
    bit        fixed;
    out_item_t want;
  } vec_t;

  function automatic longint rnd_shift(longint v, int s);
    longint mag, r;
    mag = (v < 0) ? -v : v;
    r = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint unsigned taylor_step(longint unsigned x2, longint unsigned t,
                                                  longint unsigned k);
    longint unsigned p;
    p = ((x2 * t) >> WQ) / k;
    if (p > (64'd1 << WQ)) p = 64'd1 << WQ;
    return (64'd1 << WQ) - p;
  endfunction

  // sine and cosine in Q20 of a binary angle
  function automatic void angle_sincos(input logic [15:0] ang, output longint sn,
                                       output longint cs);
    longint unsigned ks[5] = '{110, 72, 42, 20, 6};
    longint unsigned kc[6] = '{132, 90, 56, 30, 12, 2};
    logic [ANGLE_BITS-1:0] u;
    logic [1:0] q;
    longint unsigned r, x, x2, t, s0, c0;
    longint sv, cv;
    u = ANGLE_BITS'(signed'(ang));
    q = u[ANGLE_BITS-1 -: 2];
    r = u & ((64'd1 << (ANGLE_BITS - 2)) - 1);
    x = (r * 64'd1686629713) >> (ANGLE_BITS - 2);
    x2 = (x * x) >> WQ;
    t = 64'd1 << WQ;
    for (int i = 0; i < 5; i++) t = taylor_step(x2, t, ks[i]);
    s0 = (x * t) >> WQ;
    t = 64'd1 << WQ;
    for (int i = 0; i < 6; i++) t = taylor_step(x2, t, kc[i]);
    c0 = t;
    case (q)
      2'd0: begin sv = s0;  cv = c0;  end
      2'd1: begin sv = c0;  cv = -s0; end
      2'd2: begin sv = -s0; cv = -c0; end
      default: begin sv = -c0; cv = s0; end
    endcase
    sn = rnd_shift(sv, WQ - SQ);
    cs = rnd_shift(cv, WQ - SQ);
  endfunction

  function automatic logic [15:0] coef(longint v60);
    return 16'(rnd_shift(v60, 60 - COEF_FRAC_BITS));
  endfunction

  function automatic out_item_t pose_matrix(in_item_t p);
    out_item_t o;
    longint sz, cz, sy, cy, sx, cx;
    longint k20, k40;
    k20 = 64'sd1 <<< 20;
    k40 = 64'sd1 <<< 40;
    angle_sincos(p.yaw_angle, sz, cz);
    angle_sincos(p.pitch_angle, sy, cy);
    angle_sincos(p.roll_angle, sx, cx);
    o.r00 = coef(cz * cy * k20);
    o.r01 = coef(cz * sy * sx - sz * cx * k20);
    o.r02 = coef(cz * sy * cx + sz * sx * k20);
    o.r10 = coef(sz * cy * k20);
    o.r11 = coef(sz * sy * sx + cz * cx * k20);
    o.r12 = coef(sz * sy * cx - cz * sx * k20);
    o.r20 = coef(-sy * k40);
    o.r21 = coef(cy * sx * k20);
    o.r22 = coef(cy * cx * k20);
    o.trans_x = p.pos_x;
    o.trans_y = p.pos_y;
    o.trans_z = p.pos_z;
    return o;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    n_errors++;
    $display("MISMATCH item %0d %s: got %0h want %0h", n_checked, what, got, want);
  endtask

  task automatic check_pose(input out_item_t got, input out_item_t want);
    if (got.r00 !== want.r00) report("r00", 32'(got.r00), 32'(want.r00));
    if (got.r01 !== want.r01) report("r01", 32'(got.r01), 32'(want.r01));
    if (got.r02 !== want.r02) report("r02", 32'(got.r02), 32'(want.r02));
    if (got.r10 !== want.r10) report("r10", 32'(got.r10), 32'(want.r10));
    if (got.r11 !== want.r11) report("r11", 32'(got.r11), 32'(want.r11));
    if (got.r12 !== want.r12) report("r12", 32'(got.r12), 32'(want.r12));
    if (got.r20 !== want.r20) report("r20", 32'(got.r20), 32'(want.r20));
    if (got.r21 !== want.r21) report("r21", 32'(got.r21), 32'(want.r21));
    if (got.r22 !== want.r22) report("r22", 32'(got.r22), 32'(want.r22));
    if (got.trans_x !== want.trans_x) report("trans_x", got.trans_x, want.trans_x);
    if (got.trans_y !== want.trans_y) report("trans_y", got.trans_y, want.trans_y);
    if (got.trans_z !== want.trans_z) report("trans_z", got.trans_z, want.trans_z);
  endtask

  function automatic in_item_t mk(int yw, int pt, int rl, int px, int py, int pz);
    in_item_t p;
    p.yaw_angle = 16'(yw);
    p.pitch_angle = 16'(pt);
    p.roll_angle = 16'(rl);
    p.pos_x = px;
    p.pos_y = py;
    p.pos_z = pz;
    return p;
  endfunction

  function automatic out_item_t rot(int a00, int a01, int a02, int a10, int a11, int a12,
                                    int a20, int a21, int a22, int tx, int ty, int tz);
    out_item_t o;
    o = '{16'(a00), 16'(a01), 16'(a02), 16'(a10), 16'(a11), 16'(a12),
          16'(a20), 16'(a21), 16'(a22), tx, ty, tz};
    return o;
  endfunction

  function automatic in_item_t rand_pose();
    in_item_t p;
    p.yaw_angle = 16'($urandom);
    p.pitch_angle = 16'($urandom);
    p.roll_angle = 16'($urandom);
    p.pos_x = $urandom;
    p.pos_y = $urandom;
    p.pos_z = $urandom;
    // quadrant edges now and then
    if ($urandom_range(0, 7) == 0) p.yaw_angle = 16'($urandom_range(0, 3) << 14)
                                                + 16'($urandom_range(0, 2)) - 16'd1;
    if ($urandom_range(0, 7) == 0) p.pitch_angle = 16'($urandom_range(0, 3) << 14);
    return p;
  endfunction

  task automatic send_pose(input in_item_t p);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pose_q.push_back(pose_matrix(p));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pose_q.size() != 0) @(posedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        n_errors++;
        $display("MISMATCH unexpected item");
      end else begin
        check_pose(out_data, pose_q.pop_front());
      end
      n_checked++;
    end
    out_stall <= hold_off || (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (cycle_cnt >= CYC_LIMIT) begin
      $display("timeout at cycle %0d", cycle_cnt);
      $display("euler_zyx_to_pose_matrix test failed");
      $finish;
    end
  end

  vec_t dir_vecs[$];

  initial begin
    // zero, eighth, quarter and half turns, quadrant edges, binary extremes
    dir_vecs.push_back('{mk(0, 0, 0, 0, 0, 0), 1,
                         rot(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0)});
    dir_vecs.push_back('{mk(16384, 0, 0, 1, -1, 32'h7fffffff), 1,
                         rot(0, -16384, 0, 16384, 0, 0, 0, 0, 16384, 1, -1, 32'h7fffffff)});
    dir_vecs.push_back('{mk(0, 16384, 0, 32'h80000000, 0, 0), 1,
                         rot(0, 0, 16384, 0, 16384, 0, -16384, 0, 0, 32'h80000000, 0, 0)});
    dir_vecs.push_back('{mk(0, 0, 16384, 0, 32'hffffffff, 0), 1,
                         rot(16384, 0, 0, 0, 0, -16384, 0, 16384, 0, 0, -1, 0)});
    dir_vecs.push_back('{mk(-32768, 0, 0, 0, 0, 0), 1,
                         rot(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384, 0, 0, 0)});
    dir_vecs.push_back('{mk(-16384, 0, 0, 0, 0, 0), 1,
                         rot(0, 16384, 0, -16384, 0, 0, 0, 0, 16384, 0, 0, 0)});
    dir_vecs.push_back('{mk(32767, 32767, 32767, 32'h7fffffff, 32'h80000000, 32'h55555555),
                         0, '0});
    dir_vecs.push_back('{mk(-32768, -32768, -32768, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa),
                         0, '0});
    dir_vecs.push_back('{mk(1, -1, 16383, 0, 0, 0), 0, '0});
    dir_vecs.push_back('{mk(16383, 16385, -16385, 0, 0, 0), 0, '0});
    dir_vecs.push_back('{mk(8192, 8192, 8192, 0, 0, 0), 0, '0});
    dir_vecs.push_back('{mk(-8192, 24576, -24576, 0, 0, 0), 0, '0});
    dir_vecs.push_back('{mk(32767, -16383, 1, 0, 0, 0), 0, '0});
    dir_vecs.push_back('{mk(-1, -32767, 32766, 0, 0, 0), 0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_vecs[i]) begin
      if (dir_vecs[i].fixed && pose_matrix(dir_vecs[i].pose) != dir_vecs[i].want) begin
        n_errors++;
        $display("MISMATCH directed row %0d disagrees with predictor", i);
      end
      send_pose(dir_vecs[i].pose);
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (120) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < N_RANDOM / 5; n++) send_pose(rand_pose());
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (LAT + 10) @(posedge clk);
    $display("checked %0d pose items: corner angles and positions, random poses", n_checked);
    $display("under free flow, sender gaps, receiver stalls and a long output hold-off");
    if (n_errors == 0) begin
      $display("euler_zyx_to_pose_matrix test passed");
    end else begin
      $display("euler_zyx_to_pose_matrix test failed");
    end
    $finish;
  end

endmodule

/* euler_zyx_to_pose_matrix.f */
rtl/ezp_pkg.sv
rtl/ezp_nest_cell.sv
rtl/ezp_sincos.sv
rtl/ezp_matrix.sv
rtl/euler_zyx_to_pose_matrix.sv
sim/testbench.sv
